/* design/qft_pkg.sv */
// shared types and constants of the quotient filter table
`default_nettype none
package qft_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  localparam int FP_W     = 64;
  localparam int TOTAL_W  = 11;
  localparam int QREG_W   = 4;
  localparam int RREG_W   = 6;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_QUOTIENT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REMAINDER = 1'd1;

  localparam logic [QREG_W-1:0] QBITS_RESET = 4'd10;
  localparam logic [RREG_W-1:0] RBITS_RESET = 6'd32;

  // slot flag positions
  localparam int F_OCC   = 0;
  localparam int F_CONT  = 1;
  localparam int F_SHIFT = 2;
  localparam int FLAG_W  = 3;

endpackage
`default_nettype wire

/* design/qft_ram.sv */
// generic single write port, single read port ram with registered read
`default_nettype none
module qft_ram #(
  parameter int WIDTH = 35,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // same-cycle write is forwarded to the read port
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* design/qft_seq.sv */
// command sequencer: run search, sorted insert shift, remove shift back, clear sweep
`default_nettype none
module qft_seq #(
  parameter int SLOT_ADDR_BITS     = 10,
  parameter int REMAINDER_BITS_MAX = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire qft_pkg::cmd_t                     cmd,
  input  wire logic [SLOT_ADDR_BITS-1:0]         hq,
  input  wire logic [REMAINDER_BITS_MAX-1:0]     hr,
  input  wire logic                              fp_bad,
  input  wire logic [SLOT_ADDR_BITS-1:0]         imask,
  input  wire logic [SLOT_ADDR_BITS:0]           cap,
  input  wire logic                              cfg_clear,
  output logic                                   ram_we,
  output logic [SLOT_ADDR_BITS-1:0]              ram_waddr,
  output logic [REMAINDER_BITS_MAX+2:0]          ram_wdata,
  output logic [SLOT_ADDR_BITS-1:0]              ram_raddr,
  input  wire logic [REMAINDER_BITS_MAX+2:0]     ram_rdata,
  output logic                                   out_valid,
  output logic                                   out_ok,
  output logic [qft_pkg::TOTAL_W-1:0]            out_entry_total
);
  import qft_pkg::*;

  localparam int AW = SLOT_ADDR_BITS;
  localparam int RW = REMAINDER_BITS_MAX;
  localparam int EW = REMAINDER_BITS_MAX + FLAG_W;
  localparam int CW = SLOT_ADDR_BITS + 1;

  typedef enum logic [4:0] {
    S_IDLE, S_CLR, S_I_HQ, S_Q_HQ, S_R_HQ, S_F_BACK, S_F_CHK, S_F_SKIP, S_F_NOCC,
    S_SCAN, S_SCANC, S_I_POST, S_I_SHIFT, S_R_NX, S_R_CUR, S_R_LOOP, S_R_QUO, S_R_FIX
  } state_t;

  state_t          state_r, state_nxt;
  cmd_t            cmd_r, cmd_nxt;
  logic [AW-1:0]   hq_r, hq_nxt;
  logic [RW-1:0]   hr_r, hr_nxt;
  logic [EW-1:0]   hqe_r, hqe_nxt;
  logic [AW-1:0]   s_r, s_nxt;
  logic [AW-1:0]   b_r, b_nxt;
  logic [AW-1:0]   start_r, start_nxt;
  logic [EW-1:0]   st_e_r, st_e_nxt;
  logic [EW-1:0]   cur_r, cur_nxt;
  logic [EW-1:0]   nx_r, nx_nxt;
  logic [AW-1:0]   quo_r, quo_nxt;
  logic [AW-1:0]   slot_r, slot_nxt;
  logic [AW-1:0]   scan_r, scan_nxt;
  logic            rs_r, rs_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  logic            clr_cmd_r, clr_cmd_nxt;
  logic            out_valid_r, out_ok_r;
  logic [TOTAL_W-1:0] out_total_r;
  logic            done, done_ok;

  function automatic logic e_empty(input logic [EW-1:0] e);
    return (e[FLAG_W-1:0] == '0);
  endfunction

  function automatic logic run_start(input logic [EW-1:0] e);
    return !e[F_CONT] && (e[F_OCC] || e[F_SHIFT]);
  endfunction

  function automatic logic cluster_start(input logic [EW-1:0] e);
    return e[F_OCC] && !e[F_CONT] && !e[F_SHIFT];
  endfunction

  function automatic logic [AW-1:0] nxt_idx(input logic [AW-1:0] x, input logic [AW-1:0] m);
    return (x + AW'(1)) & m;
  endfunction

  function automatic logic [AW-1:0] prv_idx(input logic [AW-1:0] x, input logic [AW-1:0] m);
    return (x - AW'(1)) & m;
  endfunction

  always_comb begin
    logic [EW-1:0] prev_v;
    logic [EW-1:0] cur_v;
    logic [EW-1:0] up_v;
    logic [RW-1:0] rem_v;
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    hq_nxt      = hq_r;
    hr_nxt      = hr_r;
    hqe_nxt     = hqe_r;
    s_nxt       = s_r;
    b_nxt       = b_r;
    start_nxt   = start_r;
    st_e_nxt    = st_e_r;
    cur_nxt     = cur_r;
    nx_nxt      = nx_r;
    quo_nxt     = quo_r;
    slot_nxt    = slot_r;
    scan_nxt    = scan_r;
    rs_nxt      = rs_r;
    cnt_nxt     = cnt_r;
    clr_nxt     = clr_r;
    clr_cmd_nxt = clr_cmd_r;
    ram_we      = 1'b0;
    ram_waddr   = s_r;
    ram_wdata   = '0;
    ram_raddr   = s_r;
    done        = 1'b0;
    done_ok     = 1'b0;
    prev_v      = ram_rdata;
    cur_v       = cur_r;
    up_v        = ram_rdata;
    rem_v       = ram_rdata[EW-1:FLAG_W];

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt   = cmd;
          hq_nxt    = hq;
          hr_nxt    = hr;
          ram_raddr = hq;
          unique case (cmd)
            CMD_INSERT: begin
              if (cnt_r >= cap) begin
                done = 1'b1;
              end else begin
                state_nxt = S_I_HQ;
              end
            end
            CMD_QUERY: state_nxt = S_Q_HQ;
            CMD_REMOVE: begin
              if (fp_bad) begin
                done = 1'b1;
              end else begin
                state_nxt = S_R_HQ;
              end
            end
            CMD_CLEAR: begin
              state_nxt   = S_CLR;
              clr_nxt     = '0;
              clr_cmd_nxt = 1'b1;
              cnt_nxt     = '0;
            end
          endcase
        end
      end

      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + AW'(1);
        if (&clr_r) begin
          state_nxt = S_IDLE;
          if (clr_cmd_r) begin
            done    = 1'b1;
            done_ok = 1'b1;
          end
        end
      end

      S_I_HQ: begin
        hqe_nxt = ram_rdata;
        if (e_empty(ram_rdata)) begin
          ram_we    = 1'b1;
          ram_waddr = hq_r;
          ram_wdata = {hr_r, FLAG_W'(0)};
          ram_wdata[F_OCC] = 1'b1;
          cnt_nxt   = cnt_r + CW'(1);
          done      = 1'b1;
          done_ok   = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          if (!ram_rdata[F_OCC]) begin
            ram_we    = 1'b1;
            ram_waddr = hq_r;
            ram_wdata = ram_rdata;
            ram_wdata[F_OCC] = 1'b1;
          end
          b_nxt     = hq_r;
          ram_raddr = hq_r;
          state_nxt = S_F_BACK;
        end
      end

      S_Q_HQ: begin
        if (!ram_rdata[F_OCC]) begin
          done      = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          b_nxt     = hq_r;
          ram_raddr = hq_r;
          state_nxt = S_F_BACK;
        end
      end

      S_R_HQ: begin
        hqe_nxt = ram_rdata;
        if (!ram_rdata[F_OCC] || (cnt_r == '0)) begin
          done      = 1'b1;
          done_ok   = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          b_nxt     = hq_r;
          ram_raddr = hq_r;
          state_nxt = S_F_BACK;
        end
      end

      S_F_BACK: begin
        if (ram_rdata[F_SHIFT]) begin
          b_nxt     = prv_idx(b_r, imask);
          ram_raddr = prv_idx(b_r, imask);
        end else begin
          s_nxt     = b_r;
          state_nxt = S_F_CHK;
        end
      end

      S_F_CHK: begin
        if (b_r == hq_r) begin
          start_nxt = s_r;
          ram_raddr = s_r;
          if ((cmd_r == CMD_INSERT) && !hqe_r[F_OCC]) begin
            state_nxt = S_I_POST;
          end else begin
            state_nxt = S_SCAN;
          end
        end else begin
          s_nxt     = nxt_idx(s_r, imask);
          ram_raddr = nxt_idx(s_r, imask);
          state_nxt = S_F_SKIP;
        end
      end

      S_F_SKIP: begin
        if (ram_rdata[F_CONT]) begin
          s_nxt     = nxt_idx(s_r, imask);
          ram_raddr = nxt_idx(s_r, imask);
        end else begin
          b_nxt     = nxt_idx(b_r, imask);
          ram_raddr = nxt_idx(b_r, imask);
          state_nxt = S_F_NOCC;
        end
      end

      S_F_NOCC: begin
        if (!ram_rdata[F_OCC]) begin
          b_nxt     = nxt_idx(b_r, imask);
          ram_raddr = nxt_idx(b_r, imask);
        end else begin
          state_nxt = S_F_CHK;
        end
      end

      S_SCAN, S_SCANC: begin
        if (state_r == S_SCAN) begin
          st_e_nxt = ram_rdata;
        end
        if ((state_r == S_SCANC) && !ram_rdata[F_CONT]) begin
          if (cmd_r == CMD_INSERT) begin
            state_nxt = S_I_POST;
          end else begin
            done      = 1'b1;
            done_ok   = (cmd_r == CMD_REMOVE);
            state_nxt = S_IDLE;
          end
        end else if (rem_v == hr_r) begin
          if (cmd_r == CMD_REMOVE) begin
            rs_nxt    = run_start(ram_rdata);
            ram_raddr = nxt_idx(s_r, imask);
            state_nxt = S_R_NX;
          end else begin
            done      = 1'b1;
            done_ok   = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (rem_v > hr_r) begin
          if (cmd_r == CMD_INSERT) begin
            state_nxt = S_I_POST;
          end else begin
            done      = 1'b1;
            done_ok   = (cmd_r == CMD_REMOVE);
            state_nxt = S_IDLE;
          end
        end else begin
          s_nxt     = nxt_idx(s_r, imask);
          ram_raddr = nxt_idx(s_r, imask);
          state_nxt = S_SCANC;
        end
      end

      S_I_POST: begin
        cur_v = {hr_r, FLAG_W'(0)};
        if (hqe_r[F_OCC]) begin
          if (s_r == start_r) begin
            ram_we    = 1'b1;
            ram_waddr = start_r;
            ram_wdata = st_e_r;
            ram_wdata[F_CONT] = 1'b1;
          end else begin
            cur_v[F_CONT] = 1'b1;
          end
        end
        cur_v[F_SHIFT] = (s_r != hq_r);
        cur_nxt   = cur_v;
        ram_raddr = s_r;
        state_nxt = S_I_SHIFT;
      end

      S_I_SHIFT: begin
        if (!e_empty(ram_rdata)) begin
          prev_v[F_SHIFT] = 1'b1;
          if (ram_rdata[F_OCC]) begin
            cur_v[F_OCC]  = 1'b1;
            prev_v[F_OCC] = 1'b0;
          end
        end
        ram_we    = 1'b1;
        ram_waddr = s_r;
        ram_wdata = cur_v;
        cur_nxt   = prev_v;
        s_nxt     = nxt_idx(s_r, imask);
        if (!e_empty(ram_rdata)) begin
          ram_raddr = nxt_idx(s_r, imask);
        end else begin
          cnt_nxt   = cnt_r + CW'(1);
          done      = 1'b1;
          done_ok   = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_R_NX: begin
        if (rs_r && !ram_rdata[F_CONT]) begin
          up_v = hqe_r;
          up_v[F_OCC] = 1'b0;
          hqe_nxt   = up_v;
          ram_we    = 1'b1;
          ram_waddr = hq_r;
          ram_wdata = up_v;
        end
        slot_nxt  = s_r;
        scan_nxt  = nxt_idx(s_r, imask);
        quo_nxt   = hq_r;
        ram_raddr = s_r;
        state_nxt = S_R_CUR;
      end

      S_R_CUR: begin
        cur_nxt   = ram_rdata;
        ram_raddr = scan_r;
        state_nxt = S_R_LOOP;
      end

      S_R_LOOP: begin
        nx_nxt = ram_rdata;
        if (e_empty(ram_rdata) || cluster_start(ram_rdata) || (scan_r == s_r)) begin
          ram_we    = 1'b1;
          ram_waddr = slot_r;
          ram_wdata = '0;
          if (rs_r) begin
            ram_raddr = s_r;
            state_nxt = S_R_FIX;
          end else begin
            cnt_nxt   = cnt_r - CW'(1);
            done      = 1'b1;
            done_ok   = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (run_start(ram_rdata)) begin
          quo_nxt   = nxt_idx(quo_r, imask);
          ram_raddr = nxt_idx(quo_r, imask);
          state_nxt = S_R_QUO;
        end else begin
          up_v[F_OCC] = cur_r[F_OCC];
          ram_we    = 1'b1;
          ram_waddr = slot_r;
          ram_wdata = up_v;
          slot_nxt  = scan_r;
          cur_nxt   = ram_rdata;
          scan_nxt  = nxt_idx(scan_r, imask);
          ram_raddr = nxt_idx(scan_r, imask);
        end
      end

      S_R_QUO: begin
        if (!ram_rdata[F_OCC]) begin
          quo_nxt   = nxt_idx(quo_r, imask);
          ram_raddr = nxt_idx(quo_r, imask);
        end else begin
          up_v = nx_r;
          if (cur_r[F_OCC] && (slot_r == quo_r)) begin
            up_v[F_SHIFT] = 1'b0;
          end
          up_v[F_OCC] = cur_r[F_OCC];
          ram_we    = 1'b1;
          ram_waddr = slot_r;
          ram_wdata = up_v;
          slot_nxt  = scan_r;
          cur_nxt   = nx_r;
          scan_nxt  = nxt_idx(scan_r, imask);
          ram_raddr = nxt_idx(scan_r, imask);
          state_nxt = S_R_LOOP;
        end
      end

      S_R_FIX: begin
        up_v[F_CONT] = 1'b0;
        if ((s_r == hq_r) && run_start(up_v)) begin
          up_v[F_SHIFT] = 1'b0;
        end
        if (up_v != ram_rdata) begin
          ram_we    = 1'b1;
          ram_waddr = s_r;
          ram_wdata = up_v;
        end
        cnt_nxt   = cnt_r - CW'(1);
        done      = 1'b1;
        done_ok   = 1'b1;
        state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase

    // register write empties the table
    if (cfg_clear) begin
      state_nxt   = S_CLR;
      clr_nxt     = '0;
      clr_cmd_nxt = 1'b0;
      cnt_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      clr_cmd_r   <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      out_ok_r    <= 1'b0;
      out_total_r <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      clr_cmd_r   <= clr_cmd_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= done;
      out_ok_r    <= done_ok;
      out_total_r <= TOTAL_W'(cnt_nxt);
    end
    cmd_r   <= cmd_nxt;
    hq_r    <= hq_nxt;
    hr_r    <= hr_nxt;
    hqe_r   <= hqe_nxt;
    s_r     <= s_nxt;
    b_r     <= b_nxt;
    start_r <= start_nxt;
    st_e_r  <= st_e_nxt;
    cur_r   <= cur_nxt;
    nx_r    <= nx_nxt;
    quo_r   <= quo_nxt;
    slot_r  <= slot_nxt;
    scan_r  <= scan_nxt;
    rs_r    <= rs_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_entry_total = out_total_r;

`ifndef SYNTH
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !ram_we)
    else $error("table written while idle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cap)
    else $error("entry count above table size");

  a_result_ends_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((state_r == S_IDLE) || (state_r == S_CLR)))
    else $error("result strobe while a command is still running");

  a_clear_resets_count: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_clear |=> (cnt_r == '0))
    else $error("count not cleared by register write");
`endif

endmodule
`default_nettype wire

/* design/quotient_filter_table_top.sv */
// top level of the quotient filter table: registers, field split, sequencer and slot ram
//
// Command channel: start with in_command and in_fingerprint is taken when busy is low.
// Commands: insert, query, remove, clear. Each command gives exactly one result, shown
// for one cycle with out_valid high, carrying out_ok and out_entry_total (stored item
// count after the command). The receiver cannot stall; results are never held.
// Every step of the sequencer is one read of the slot ram, so a command ends soonest
// at its home slot; otherwise its time grows with the back-walk, the runs skipped,
// the scan and the shift, all bounded by the length of the cluster. A new command is
// taken only after the last one is done. Clear sweeps every slot of the ram.
// Reset: a clearing pass over every slot runs with busy high; quotient_bits resets
// to 10, remainder_bits to 32. Configuration (cfg_valid/cfg_ready, always ready) is to
// be written by the user only while idle; the block does not enforce it. Any register
// write empties the table with the same pass.
`default_nettype none
module quotient_filter_table_top #(
  parameter int SLOT_ADDR_BITS     = 10,
  parameter int REMAINDER_BITS_MAX = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [1:0]                       in_command,
  input  wire logic [qft_pkg::FP_W-1:0]         in_fingerprint,
  output logic                                  out_valid,
  output logic                                  out_ok,
  output logic [qft_pkg::TOTAL_W-1:0]           out_entry_total,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [qft_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [qft_pkg::RREG_W-1:0]       cfg_wdata
);
  import qft_pkg::*;

  localparam int AW = SLOT_ADDR_BITS;
  localparam int RW = REMAINDER_BITS_MAX;
  localparam int EW = REMAINDER_BITS_MAX + FLAG_W;
  localparam int QW = $clog2(SLOT_ADDR_BITS + 1);
  localparam int UW = $clog2(REMAINDER_BITS_MAX + 1);
  localparam int WW = $clog2(SLOT_ADDR_BITS + REMAINDER_BITS_MAX + 1);

  logic [QREG_W-1:0] qbits_r;
  logic [RREG_W-1:0] rbits_r;
  logic              cfg_wr;
  logic [QW-1:0]     q_use;
  logic [UW-1:0]     r_use;
  logic [WW-1:0]     width_use;
  logic [AW-1:0]     imask;
  logic [AW:0]       cap;
  logic [FP_W-1:0]   hr_full;
  logic [FP_W-1:0]   hq_full;
  logic [AW-1:0]     hq;
  logic [RW-1:0]     hr;
  logic              fp_bad;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [EW-1:0]     ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [EW-1:0]     ram_rdata;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qbits_r <= QBITS_RESET;
      rbits_r <= RBITS_RESET;
    end else if (cfg_wr) begin
      if (cfg_index == REG_QUOTIENT) begin
        qbits_r <= cfg_wdata[QREG_W-1:0];
      end else begin
        rbits_r <= cfg_wdata;
      end
    end
  end

  // clamp register values to the built table
  assign q_use = (qbits_r == '0) ? QW'(1) :
                 (qbits_r > SLOT_ADDR_BITS) ? QW'(SLOT_ADDR_BITS) : QW'(qbits_r);
  assign r_use = (rbits_r == '0) ? UW'(1) :
                 (rbits_r > REMAINDER_BITS_MAX) ? UW'(REMAINDER_BITS_MAX) : UW'(rbits_r);
  assign width_use = WW'(q_use) + WW'(r_use);

  assign imask = ~({AW{1'b1}} << q_use);
  assign cap   = {{AW{1'b0}}, 1'b1} << q_use;

  assign hr_full = in_fingerprint & ~({FP_W{1'b1}} << r_use);
  assign hq_full = in_fingerprint >> r_use;
  assign hr      = hr_full[RW-1:0];
  assign hq      = hq_full[AW-1:0] & imask;
  assign fp_bad  = |(in_fingerprint & ({FP_W{1'b1}} << width_use));

  qft_seq #(
    .SLOT_ADDR_BITS     (SLOT_ADDR_BITS),
    .REMAINDER_BITS_MAX (REMAINDER_BITS_MAX)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .cmd             (cmd_t'(in_command)),
    .hq              (hq),
    .hr              (hr),
    .fp_bad          (fp_bad),
    .imask           (imask),
    .cap             (cap),
    .cfg_clear       (cfg_wr),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata),
    .out_valid       (out_valid),
    .out_ok          (out_ok),
    .out_entry_total (out_entry_total)
  );

  qft_ram #(
    .WIDTH (EW),
    .DEPTH (1 << SLOT_ADDR_BITS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
`default_nettype wire
